// ===== design/cashchk_pkg.sv =====
// ----------------------------------------------------------------------------
// cashchk_pkg
// Types, constants and helper functions for the CashAddr string checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cashchk_pkg;

  // Longest string accepted, in bytes
  localparam int MaxLength    = 1024;
  localparam int MinLength    = 8;
  localparam int CheckSymbols = 8;
  localparam int DelayDepth   = 8;

  // Counters saturate at MaxLength + 1
  localparam int CntW  = $clog2(MaxLength + 2);
  localparam int FillW = $clog2(DelayDepth + 1);
  localparam int SymW  = 5;
  localparam int CrcW  = 40;

  localparam logic [CrcW-1:0] CrcInit = CrcW'(1);

  localparam logic [CrcW-1:0] Gen [5] = '{
    40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4, 40'hae2eabe2a8, 40'h1e4f43e470
  };

  localparam logic [7:0] SepChar = 8'h3a;

  typedef enum logic [1:0] {
    KindNone    = 2'd0,
    KindPrefix  = 2'd1,
    KindPayload = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrLength   = 3'd1,
    ErrShort    = 3'd2,
    ErrPrefChar = 3'd3,
    ErrPayChar  = 3'd4,
    ErrMixCase  = 3'd5,
    ErrChecksum = 3'd6
  } err_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] value;
    logic       done_res;
    logic       accepted;
    err_e       error_code;
  } out_item_t;

  typedef struct packed {
    logic            ok;
    logic [SymW-1:0] sym;
  } sym_t;

  // One polymod step: shift in five zero bits and fold the top five back in
  function automatic logic [CrcW-1:0] poly_step(logic [CrcW-1:0] c);
    logic [4:0]      top;
    logic [CrcW-1:0] r;
    top = c[CrcW-1:CrcW-5];
    r   = {c[CrcW-6:0], 5'b00000};
    for (int k = 0; k < 5; k++) begin
      if (top[k]) begin
        r = r ^ Gen[k];
      end
    end
    return r;
  endfunction

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] v);
    return (v < CntW'(MaxLength + 1)) ? v + CntW'(1) : v;
  endfunction

  // Base-32 charset, case-insensitive
  function automatic sym_t symbol_of(logic [7:0] ch);
    logic [6:0] c;
    sym_t       s;
    c = ch[6:0];
    if (c >= 7'd97 && c <= 7'd122) begin
      c = c - 7'd32;
    end
    s.ok = 1'b1;
    case (c)
      7'd48:   s.sym = 5'd15;
      7'd50:   s.sym = 5'd10;
      7'd51:   s.sym = 5'd17;
      7'd52:   s.sym = 5'd21;
      7'd53:   s.sym = 5'd20;
      7'd54:   s.sym = 5'd26;
      7'd55:   s.sym = 5'd30;
      7'd56:   s.sym = 5'd7;
      7'd57:   s.sym = 5'd5;
      7'd65:   s.sym = 5'd29;
      7'd67:   s.sym = 5'd24;
      7'd68:   s.sym = 5'd13;
      7'd69:   s.sym = 5'd25;
      7'd70:   s.sym = 5'd9;
      7'd71:   s.sym = 5'd8;
      7'd72:   s.sym = 5'd23;
      7'd74:   s.sym = 5'd18;
      7'd75:   s.sym = 5'd22;
      7'd76:   s.sym = 5'd31;
      7'd77:   s.sym = 5'd27;
      7'd78:   s.sym = 5'd19;
      7'd80:   s.sym = 5'd1;
      7'd81:   s.sym = 5'd0;
      7'd82:   s.sym = 5'd3;
      7'd83:   s.sym = 5'd16;
      7'd84:   s.sym = 5'd11;
      7'd85:   s.sym = 5'd28;
      7'd86:   s.sym = 5'd12;
      7'd87:   s.sym = 5'd14;
      7'd88:   s.sym = 5'd6;
      7'd89:   s.sym = 5'd4;
      7'd90:   s.sym = 5'd2;
      default: begin
        s.ok  = 1'b0;
        s.sym = '0;
      end
    endcase
    if (ch[7]) begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/cashchk_in_stage.sv =====
// ----------------------------------------------------------------------------
// cashchk_in_stage
// Input register: holds one byte until the checker core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cashchk_in_stage (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  cashchk_pkg::in_item_t in_data_i,
  input  wire                   take_i,
  output logic                  valid_o,
  output cashchk_pkg::in_item_t data_o
);

  logic                  valid_q;
  cashchk_pkg::in_item_t data_q;

  // full and not draining this cycle
  assign in_stall_o = valid_q && !take_i;
  assign valid_o    = valid_q;
  assign data_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/cashchk_core.sv =====
// ----------------------------------------------------------------------------
// cashchk_core
// Per-byte checker step: polymod checksum, phase, counters, case flags,
// symbol delay line and the verdict on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cashchk_core (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    fire_i,
  input  cashchk_pkg::in_item_t  item_i,
  output cashchk_pkg::out_item_t res_o
);

  logic [cashchk_pkg::CrcW-1:0]  crc_q, crc_d, crc_n;
  logic                          sep_q, sep_d, sep_n;
  logic [cashchk_pkg::CntW-1:0]  total_q, total_d, total_n;
  logic [cashchk_pkg::CntW-1:0]  prefix_q, prefix_d, prefix_n;
  logic [cashchk_pkg::CntW-1:0]  pay_len;
  logic [cashchk_pkg::FillW-1:0] fill_q, fill_d, fill_n;
  logic                          lower_q, lower_d, lower_n;
  logic                          upper_q, upper_d, upper_n;
  cashchk_pkg::err_e             cerr_q, cerr_d, cerr_n;
  logic [cashchk_pkg::SymW-1:0]  dly_q [cashchk_pkg::DelayDepth];
  logic                          push;
  logic [7:0]                    ch;
  logic [7:0]                    low;
  logic                          is_upper;
  cashchk_pkg::sym_t             s;
  cashchk_pkg::out_item_t        res;

  assign ch       = item_i.char_in;
  assign is_upper = (ch >= 8'h41) && (ch <= 8'h5a);
  assign low      = is_upper ? ch + 8'd32 : ch;
  assign s        = cashchk_pkg::symbol_of(ch);

  always_comb begin
    crc_n    = crc_q;
    sep_n    = sep_q;
    total_n  = cashchk_pkg::sat_inc(total_q);
    prefix_n = prefix_q;
    fill_n   = fill_q;
    lower_n  = lower_q || ((ch >= 8'h61) && (ch <= 8'h7a));
    upper_n  = upper_q || is_upper;
    cerr_n   = cerr_q;
    push     = 1'b0;
    res      = '0;

    if (!sep_q) begin
      if (ch == cashchk_pkg::SepChar) begin
        sep_n = 1'b1;
        crc_n = cashchk_pkg::poly_step(crc_q);
      end else begin
        prefix_n = cashchk_pkg::sat_inc(prefix_q);
        if (ch < 8'd33 || ch > 8'd126) begin
          if (cerr_q == cashchk_pkg::ErrNone) begin
            cerr_n = cashchk_pkg::ErrPrefChar;
          end
        end else begin
          crc_n     = cashchk_pkg::poly_step(crc_q)
                      ^ {{(cashchk_pkg::CrcW-5){1'b0}}, low[4:0]};
          res.kind  = cashchk_pkg::KindPrefix;
          res.value = low[6:0];
        end
      end
    end else begin
      if (!s.ok) begin
        if (cerr_q == cashchk_pkg::ErrNone) begin
          cerr_n = cashchk_pkg::ErrPayChar;
        end
      end else begin
        push  = 1'b1;
        crc_n = cashchk_pkg::poly_step(crc_q)
                ^ {{(cashchk_pkg::CrcW-cashchk_pkg::SymW){1'b0}}, s.sym};
        if (fill_q >= cashchk_pkg::FillW'(cashchk_pkg::CheckSymbols)) begin
          res.kind  = cashchk_pkg::KindPayload;
          res.value = {{(7-cashchk_pkg::SymW){1'b0}}, dly_q[0]};
        end else begin
          fill_n = fill_q + cashchk_pkg::FillW'(1);
        end
      end
    end

    // bytes after the separator; only looked at once the length check passed
    pay_len = total_n - prefix_n - cashchk_pkg::CntW'(1);

    if (item_i.last_char) begin
      res.done_res = 1'b1;
      if (total_n < cashchk_pkg::CntW'(cashchk_pkg::MinLength) ||
          total_n > cashchk_pkg::CntW'(cashchk_pkg::MaxLength)) begin
        res.error_code = cashchk_pkg::ErrLength;
      end else if (!sep_n || prefix_n == '0 ||
                   pay_len < cashchk_pkg::CntW'(cashchk_pkg::CheckSymbols)) begin
        res.error_code = cashchk_pkg::ErrShort;
      end else if (cerr_n != cashchk_pkg::ErrNone) begin
        res.error_code = cerr_n;
      end else if (lower_n && upper_n) begin
        res.error_code = cashchk_pkg::ErrMixCase;
      end else if (crc_n != cashchk_pkg::CrcInit) begin
        res.error_code = cashchk_pkg::ErrChecksum;
      end
      res.accepted = (res.error_code == cashchk_pkg::ErrNone);
    end
  end

  assign res_o = res;

  always_comb begin
    crc_d    = crc_q;
    sep_d    = sep_q;
    total_d  = total_q;
    prefix_d = prefix_q;
    fill_d   = fill_q;
    lower_d  = lower_q;
    upper_d  = upper_q;
    cerr_d   = cerr_q;
    if (fire_i) begin
      if (item_i.last_char) begin
        crc_d    = cashchk_pkg::CrcInit;
        sep_d    = 1'b0;
        total_d  = '0;
        prefix_d = '0;
        fill_d   = '0;
        lower_d  = 1'b0;
        upper_d  = 1'b0;
        cerr_d   = cashchk_pkg::ErrNone;
      end else begin
        crc_d    = crc_n;
        sep_d    = sep_n;
        total_d  = total_n;
        prefix_d = prefix_n;
        fill_d   = fill_n;
        lower_d  = lower_n;
        upper_d  = upper_n;
        cerr_d   = cerr_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= cashchk_pkg::CrcInit;
      sep_q    <= 1'b0;
      total_q  <= '0;
      prefix_q <= '0;
      fill_q   <= '0;
      lower_q  <= 1'b0;
      upper_q  <= 1'b0;
      cerr_q   <= cashchk_pkg::ErrNone;
    end else begin
      crc_q    <= crc_d;
      sep_q    <= sep_d;
      total_q  <= total_d;
      prefix_q <= prefix_d;
      fill_q   <= fill_d;
      lower_q  <= lower_d;
      upper_q  <= upper_d;
      cerr_q   <= cerr_d;
    end
  end

  // Delay line always shifts toward entry 0; entry 0 is only read once
  // eight symbols are in, so it then holds the oldest one.
  always_ff @(posedge clk_i) begin
    if (fire_i && push) begin
      for (int i = 0; i < cashchk_pkg::DelayDepth - 1; i++) begin
        dly_q[i] <= dly_q[i+1];
      end
      dly_q[cashchk_pkg::DelayDepth-1] <= s.sym;
    end
  end

  a_reset_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.last_char |=>
      crc_q == cashchk_pkg::CrcInit && !sep_q && total_q == '0 && fill_q == '0)
    else $error("string state not cleared after last byte");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cashchk_pkg::FillW'(cashchk_pkg::DelayDepth))
    else $error("delay fill count out of range");

  a_prefix_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.kind == cashchk_pkg::KindPrefix |-> !sep_q && prefix_n != prefix_q)
    else $error("prefix character released outside prefix phase");

  a_no_sep_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sep_q |-> fill_q == '0)
    else $error("payload symbols stored before separator");

endmodule

`default_nettype wire

// ===== design/cashchk_out_stage.sv =====
// ----------------------------------------------------------------------------
// cashchk_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cashchk_out_stage (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    src_valid_i,
  input  cashchk_pkg::out_item_t res_i,
  output logic                   take_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output cashchk_pkg::out_item_t out_data_o
);

  logic                   valid_q;
  logic                   room;
  cashchk_pkg::out_item_t data_q;

  assign room        = !valid_q || !out_stall_i;
  assign take_o      = src_valid_i && room;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (room) begin
      valid_q <= src_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      data_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/cashaddr_string_checker.sv =====
// ----------------------------------------------------------------------------
// cashaddr_string_checker
// CashAddr string checker: BCH polymod checksum verification, one byte per
// transfer, payload symbols released eight symbols late, verdict on last byte.
// ----------------------------------------------------------------------------
//   channel | direction | signals                           | struct
//   --------+-----------+-----------------------------------+-----------------
//   in      | input     | in_valid_i, in_stall_o, in_data_i  | in_item_t
//   out     | output    | out_valid_o, out_stall_i, out_data_o | out_item_t
//
// One result per input byte; each byte passes through the input register and then the result
// register, and one byte is taken every cycle while the output is not stalled.
// The checksum step and charset lookup sit between the two registers.
// Reset clears all string state but the delay line contents, unread until refilled; no clearing pass is needed.
// A stall on the output holds the result register and, once the input
// register is full, stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module cashaddr_string_checker (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  cashchk_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output cashchk_pkg::out_item_t out_data_o
);

  logic                   stg_valid;
  cashchk_pkg::in_item_t  stg_data;
  logic                   take;
  cashchk_pkg::out_item_t res;

  cashchk_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .valid_o    (stg_valid),
    .data_o     (stg_data)
  );

  cashchk_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (take),
    .item_i (stg_data),
    .res_o  (res)
  );

  cashchk_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (stg_valid),
    .res_i       (res),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_accept_matches_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.accepted == (out_data_o.done_res &&
                              out_data_o.error_code == cashchk_pkg::ErrNone))
    else $error("accepted flag disagrees with error code");

  a_idle_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == cashchk_pkg::KindNone |-> out_data_o.value == '0)
    else $error("value set with nothing released");

endmodule

`default_nettype wire

// ===== dv/cashaddr_string_checker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cashaddr_string_checker_test
// Streams address strings through the checker. About half are well-formed with
// random content and a correct checksum, the rest are corrupted or noise. A
// local predictor tracks the polymod checksum, the symbol delay line and the
// verdict, and every result transfer is checked in order, field by field.
// ----------------------------------------------------------------------------
module cashaddr_string_checker_test;
  import cashchk_pkg::*;

  localparam int RunLimit   = 500000;
  localparam int SmallItems = 1450;
  localparam int QuietTail  = 250;
  localparam int LongHold   = 80;

  localparam logic [4:0][CrcW-1:0] BchTaps = {
    40'h1e4f43e470, 40'hae2eabe2a8, 40'hf33e5fb3c4, 40'h79b76d99e2, 40'h98f2bc8e61
  };
  // symbol value i is the character at position i
  localparam logic [8*32-1:0] Alphabet = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  in_item_t  in_data     = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  logic      burst_stall = 1'b0;
  logic      hold_stall  = 1'b0;
  wire       out_stall   = burst_stall | hold_stall;

  // checker state as predicted
  logic [CrcW-1:0]  crc_acc;
  logic             sep_seen;
  logic [CntW-1:0]  total_cnt;
  logic [CntW-1:0]  prefix_cnt;
  logic [SymW-1:0]  sym_line [DelayDepth];
  logic [FillW-1:0] line_fill;
  logic             saw_lo;
  logic             saw_up;
  err_e             first_bad;

  in_item_t   pending_bytes [$];
  out_item_t  expected_results [$];
  logic [7:0] str_buf [$];

  int   queued      = 0;
  int   in_count    = 0;
  int   out_count   = 0;
  int   mismatches  = 0;
  int   cycle_cnt   = 0;
  int   send_gap    = 0;
  int   stall_left  = 0;
  int   hold_left   = 0;
  bit   hold_done   = 1'b0;
  logic in_took     = 1'b0;

  cashaddr_string_checker dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [CrcW-1:0] crc_shift5(logic [CrcW-1:0] c);
    logic [CrcW-1:0] r;
    r = {c[CrcW-6:0], 5'b00000};
    for (int k = 0; k < 5; k++) begin
      if (c[CrcW-5+k]) begin
        r = r ^ BchTaps[k];
      end
    end
    return r;
  endfunction

  function automatic logic [CntW-1:0] bump(logic [CntW-1:0] v);
    return (v <= CntW'(MaxLength)) ? v + CntW'(1) : v;
  endfunction

  function automatic logic lookup_symbol(input logic [7:0] ch, output logic [SymW-1:0] sym);
    logic [7:0] lc;
    logic       hit;
    lc  = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
    hit = 1'b0;
    sym = '0;
    for (int i = 0; i < 32; i++) begin
      if (!hit && Alphabet[8*(31-i) +: 8] == lc) begin
        hit = 1'b1;
        sym = SymW'(i);
      end
    end
    return hit;
  endfunction

  function automatic logic [7:0] symbol_char(logic [SymW-1:0] s, logic upper);
    logic [7:0] ch;
    ch = Alphabet[8*(31-s) +: 8];
    if (upper && ch >= "a") begin
      ch = ch - 8'd32;
    end
    return ch;
  endfunction

  function automatic void clear_string_state();
    crc_acc    = CrcW'(1);
    sep_seen   = 1'b0;
    total_cnt  = '0;
    prefix_cnt = '0;
    line_fill  = '0;
    saw_lo     = 1'b0;
    saw_up     = 1'b0;
    first_bad  = ErrNone;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t       r;
    logic [7:0]      ch;
    logic [7:0]      lc;
    logic [SymW-1:0] sym;
    err_e            verdict;
    ch           = it.char_in;
    r.kind       = KindNone;
    r.value      = '0;
    r.done_res   = 1'b0;
    r.accepted   = 1'b0;
    r.error_code = ErrNone;
    total_cnt    = bump(total_cnt);
    if (ch >= "a" && ch <= "z") begin
      saw_lo = 1'b1;
    end
    if (ch >= "A" && ch <= "Z") begin
      saw_up = 1'b1;
    end
    if (!sep_seen) begin
      if (ch == SepChar) begin
        sep_seen = 1'b1;
        crc_acc  = crc_shift5(crc_acc);
      end else begin
        prefix_cnt = bump(prefix_cnt);
        if (ch < 8'd33 || ch > 8'd126) begin
          if (first_bad == ErrNone) begin
            first_bad = ErrPrefChar;
          end
        end else begin
          lc      = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
          crc_acc = crc_shift5(crc_acc) ^ CrcW'(lc[4:0]);
          r.kind  = KindPrefix;
          r.value = lc[6:0];
        end
      end
    end else if (!lookup_symbol(ch, sym)) begin
      if (first_bad == ErrNone) begin
        first_bad = ErrPayChar;
      end
    end else begin
      crc_acc = crc_shift5(crc_acc) ^ CrcW'(sym);
      // line full: oldest symbol leaves, so the check symbols never do
      if (line_fill >= FillW'(CheckSymbols)) begin
        r.kind  = KindPayload;
        r.value = {2'b00, sym_line[0]};
        for (int i = 0; i < DelayDepth - 1; i++) begin
          sym_line[i] = sym_line[i+1];
        end
        sym_line[DelayDepth-1] = sym;
      end else begin
        sym_line[line_fill[2:0]] = sym;
        line_fill                = line_fill + FillW'(1);
      end
    end
    if (it.last_char) begin
      verdict = ErrNone;
      if (total_cnt < MinLength || total_cnt > MaxLength) begin
        verdict = ErrLength;
      end else if (!sep_seen || prefix_cnt == 0 ||
                   int'(total_cnt) - int'(prefix_cnt) - 1 < CheckSymbols) begin
        verdict = ErrShort;
      end else if (first_bad != ErrNone) begin
        verdict = first_bad;
      end else if (saw_lo && saw_up) begin
        verdict = ErrMixCase;
      end else if (crc_acc != CrcW'(1)) begin
        verdict = ErrChecksum;
      end
      r.done_res   = 1'b1;
      r.accepted   = (verdict == ErrNone);
      r.error_code = verdict;
      clear_string_state();
    end
    return r;
  endfunction

  function automatic logic [7:0] prefix_char();
    logic [7:0] ch;
    ch = "a" + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 9) > 6) begin
      do begin
        ch = 8'($urandom_range(33, 126));
      end while (ch == SepChar || (ch >= "A" && ch <= "Z"));
    end
    return ch;
  endfunction

  // well-formed address with a correct checksum
  function automatic void build_address(int plen, int paylen, logic upper);
    logic [CrcW-1:0] c;
    logic [7:0]      ch;
    logic [SymW-1:0] s;
    str_buf.delete();
    c = CrcW'(1);
    for (int i = 0; i < plen; i++) begin
      ch = prefix_char();
      c  = crc_shift5(c) ^ CrcW'(ch[4:0]);
      if (upper && ch >= "a" && ch <= "z") begin
        ch = ch - 8'd32;
      end
      str_buf.push_back(ch);
    end
    str_buf.push_back(SepChar);
    c = crc_shift5(c);
    for (int i = 0; i < paylen; i++) begin
      s = SymW'($urandom);
      c = crc_shift5(c) ^ CrcW'(s);
      str_buf.push_back(symbol_char(s, upper));
    end
    for (int i = 0; i < CheckSymbols; i++) begin
      c = crc_shift5(c);
    end
    c = c ^ CrcW'(1);
    for (int i = 0; i < CheckSymbols; i++) begin
      str_buf.push_back(symbol_char(c[CrcW-1-5*i -: 5], upper));
    end
  endfunction

  function automatic void send_string();
    in_item_t it;
    foreach (str_buf[i]) begin
      it.char_in   = str_buf[i];
      it.last_char = (i == str_buf.size() - 1);
      pending_bytes.push_back(it);
    end
    queued += str_buf.size();
  endfunction

  // no idling near the end and in a recurring window
  function automatic logic quiet_now();
    return (queued - in_count) <= QuietTail || (in_count % 512) >= 448;
  endfunction

  initial begin
    int              plen;
    int              paylen;
    int              pick;
    int              pos;
    logic            upper;
    logic            flipped;
    logic [7:0]      ch;
    logic [SymW-1:0] s;
    bit              long_sent;

    clear_string_state();
    long_sent = 1'b0;

    // shortest well-formed address, a too-short string of three non-printing
    // bytes, an upper-case address with one released symbol, a lone separator
    build_address(1, 0, 1'b0);
    send_string();
    str_buf = '{8'h00, 8'hff, 8'h7f};
    send_string();
    build_address(1, 1, 1'b1);
    send_string();
    str_buf = '{SepChar};
    send_string();

    while (queued < SmallItems) begin
      if (!long_sent && queued > SmallItems / 4) begin
        // one string at the length limit or one past it
        long_sent = 1'b1;
        plen      = $urandom_range(1, 8);
        build_address(plen, $urandom_range(1024, 1025) - plen - 9,
                      1'($urandom_range(0, 1)));
        send_string();
      end else begin
        pick   = $urandom_range(0, 99);
        plen   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        paylen = $urandom_range(0, 34);
        upper  = ($urandom_range(0, 9) < 3);
        if (pick >= 81 && pick <= 83) begin
          plen = 0;
        end
        if (pick >= 84 && pick <= 88) begin
          paylen = 0;
        end
        build_address(plen, paylen, upper);
        pos = plen + 1 + $urandom_range(0, str_buf.size() - plen - 2);
        if (pick >= 50 && pick <= 57) begin
          // one symbol replaced by another
          void'(lookup_symbol(str_buf[pos], s));
          s            = s ^ SymW'($urandom_range(1, 31));
          str_buf[pos] = symbol_char(s, upper);
        end else if (pick >= 58 && pick <= 64) begin
          if ($urandom_range(0, 2) == 0) begin
            ch = SepChar;
          end else begin
            do begin
              ch = 8'($urandom_range(0, 255));
            end while (lookup_symbol(ch, s));
          end
          str_buf[pos] = ch;
        end else if (pick >= 65 && pick <= 70) begin
          ch = $urandom_range(0, 1) ? 8'($urandom_range(0, 32)) : 8'($urandom_range(127, 255));
          str_buf[$urandom_range(0, plen - 1)] = ch;
        end else if (pick >= 71 && pick <= 76) begin
          // flip the case of one letter
          flipped = 1'b0;
          for (int j = 0; j < str_buf.size(); j++) begin
            ch = str_buf[(pos + j) % str_buf.size()] | 8'h20;
            if (!flipped && ch >= "a" && ch <= "z") begin
              str_buf[(pos + j) % str_buf.size()] ^= 8'h20;
              flipped = 1'b1;
            end
          end
        end else if (pick >= 77 && pick <= 80) begin
          str_buf.delete(plen);
        end else if (pick >= 84 && pick <= 88) begin
          // cut into the check symbols
          repeat ($urandom_range(1, 8)) begin
            void'(str_buf.pop_back());
          end
        end else if (pick >= 89) begin
          str_buf.delete();
          repeat ($urandom_range(1, 30)) begin
            ch = ($urandom_range(0, 7) == 0) ? SepChar : 8'($urandom_range(0, 255));
            str_buf.push_back(ch);
          end
        end
        send_string();
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // byte driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet_now() && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // short random stalls on the result side
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      burst_stall <= 1'b1;
    end else if (!quiet_now() && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 6);
      burst_stall <= 1'b1;
    end else begin
      burst_stall <= 1'b0;
    end
  end

  // one long hold-off so the checker backs up into its input
  always @(negedge clk) begin
    if (!hold_done && in_count >= 300) begin
      hold_done = 1'b1;
      hold_left = LongHold;
    end
    hold_stall <= (hold_left != 0);
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_result(in_data));
        in_count <= in_count + 1;
      end
      if (out_valid && !out_stall) begin
        out_count = out_count + 1;
        if (expected_results.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("result %0d with none expected: kind %0d value %0d done %0d acc %0d err %0d",
                     out_count, out_data.kind, out_data.value, out_data.done_res,
                     out_data.accepted, out_data.error_code);
          end
        end else begin
          want = expected_results.pop_front();
          if (out_data.kind != want.kind || out_data.value != want.value ||
              out_data.done_res != want.done_res || out_data.accepted != want.accepted ||
              out_data.error_code != want.error_code) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("result %0d: expected kind %0d value %0d done %0d acc %0d err %0d",
                       out_count, want.kind, want.value, want.done_res, want.accepted,
                       want.error_code);
              $display("           got      kind %0d value %0d done %0d acc %0d err %0d",
                       out_data.kind, out_data.value, out_data.done_res, out_data.accepted,
                       out_data.error_code);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= RunLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
design/cashchk_pkg.sv
design/cashchk_in_stage.sv
design/cashchk_core.sv
design/cashchk_out_stage.sv
design/cashaddr_string_checker.sv
dv/cashaddr_string_checker_test.sv
